[hw/rtl/crd_pkg.sv]
package crd_pkg;

    // report buffer
    localparam int REPORT_BYTES = 22;
    localparam int BUF_SLOTS    = 32;
    localparam int BUF_AW       = $clog2(BUF_SLOTS);
    localparam int POS_W        = $clog2(REPORT_BYTES + 1);

    // job queue between front and back
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    localparam logic [5:0] CFG_MODE_RESET = 6'd55;

    // report types
    localparam logic [7:0] RPT_STATUS           = 8'h20;
    localparam logic [7:0] RPT_READ             = 8'h21;
    localparam logic [7:0] RPT_CORE             = 8'h30;
    localparam logic [7:0] RPT_CORE_ACC         = 8'h31;
    localparam logic [7:0] RPT_CORE_EXT8        = 8'h32;
    localparam logic [7:0] RPT_CORE_ACC_IR      = 8'h33;
    localparam logic [7:0] RPT_CORE_EXT19       = 8'h34;
    localparam logic [7:0] RPT_CORE_ACC_EXT16   = 8'h35;
    localparam logic [7:0] RPT_CORE_IR_EXT9     = 8'h36;
    localparam logic [7:0] RPT_CORE_ACC_IR_EXT6 = 8'h37;
    localparam logic [7:0] RPT_EXT21            = 8'h3D;

    // attachment types
    localparam logic [7:0] ATT_NONE      = 8'h00;
    localparam logic [7:0] ATT_STICK_PAD = 8'hFE;
    localparam logic [7:0] ATT_DUAL_PAD  = 8'hFD;

    // attachment query answer markers
    localparam logic [7:0] READ_ADDR_MARK = 8'h10;
    localparam logic [7:0] READ_ID_MARK   = 8'hFE;

    localparam logic [7:0] EXT_KEY  = 8'h17;
    localparam logic [9:0] IR_NONE  = 10'd1023;
    localparam logic [10:0] IR_SPAN = 11'd1024;

    // event kinds, emitted in increasing order within a report
    localparam int EV_COUNT = 13;
    localparam logic [3:0] EV_BUTTONS   = 4'd0;
    localparam logic [3:0] EV_ACCEL     = 4'd1;
    localparam logic [3:0] EV_IR        = 4'd2;
    localparam logic [3:0] EV_SP_BTN    = 4'd3;
    localparam logic [3:0] EV_SP_ACCEL  = 4'd4;
    localparam logic [3:0] EV_SP_STICK  = 4'd5;
    localparam logic [3:0] EV_DP_BTN    = 4'd6;
    localparam logic [3:0] EV_DP_LEFT   = 4'd7;
    localparam logic [3:0] EV_DP_RIGHT  = 4'd8;
    localparam logic [3:0] EV_DP_TRIG   = 4'd9;
    localparam logic [3:0] EV_ATTACH    = 4'd10;
    localparam logic [3:0] EV_QUERY     = 4'd11;
    localparam logic [3:0] EV_REINIT    = 4'd12;

    // one classified report
    typedef struct packed {
        logic [EV_COUNT-1:0] mask;
        logic [15:0]         buttons;
        logic [7:0]          acc_x;
        logic [7:0]          acc_y;
        logic [7:0]          acc_z;
        logic [10:0]         ir_x;
        logic [9:0]          ir_y;
        logic [5:0][7:0]     ext;
        logic [7:0]          att;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

endpackage

[hw/rtl/controller_report_decoder.sv]
// channel   | direction | ports
// s_        | in        | s_valid, s_ready, s_report_byte, s_last_byte
// m_        | out       | m_valid, m_ready, m_event_kind, m_value_a..c, m_last_of_run
// cfg_      | in        | cfg_valid, cfg_ready, cfg_data (configured report mode)
//
// one report byte per cycle is taken while the four-entry job queue has room
// a report is decoded in the cycle of its last byte and goes via the queue and job register to m_
// events leave via the back-end output register one per cycle unless stalled, up to seven per report
// the output side drains the queue, so s_ready drops only when four decoded reports wait
// reset (aresetn low at a clock edge) empties the buffer and queue, clears the attachment
// type and sets the configured mode to 0x37; cfg_ready is always high
module controller_report_decoder import crd_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    // report byte requests
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_report_byte,
    input  logic        s_last_byte,
    // event requests
    output logic        m_valid,
    input  logic        m_ready,
    output logic [3:0]  m_event_kind,
    output logic [15:0] m_value_a,
    output logic [9:0]  m_value_b,
    output logic [7:0]  m_value_c,
    output logic        m_last_of_run,
    // mode register write requests
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [5:0]  cfg_data
);

    // configured report mode, compared against 0x30 reports
    logic [5:0] mode_reg, mode_next;

    // front to queue
    logic    job_push;
    job_t    job;
    // queue to back
    logic    job_pop;
    job_t    head_job;
    q_stat_t q_stat;

    assign cfg_ready = 1'b1;
    assign mode_next = (cfg_valid && cfg_ready) ? cfg_data : mode_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= CFG_MODE_RESET;
        end else begin
            mode_reg <= mode_next;
        end
    end

    // front: buffers bytes, classifies the report on its last byte
    crd_front u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_report_byte   (s_report_byte),
        .s_last_byte     (s_last_byte),
        .configured_mode (mode_reg),
        .q_stat          (q_stat),
        .job_push        (job_push),
        .job             (job)
    );

    // decoded reports waiting for the back end
    crd_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (job_push),
        .push_job (job),
        .pop      (job_pop),
        .head_job (head_job),
        .stat     (q_stat)
    );

    // back: walks the event mask of one report, one event per cycle while the output is not stalled
    crd_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_stat        (q_stat),
        .head_job      (head_job),
        .pop           (job_pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_event_kind  (m_event_kind),
        .m_value_a     (m_value_a),
        .m_value_b     (m_value_b),
        .m_value_c     (m_value_c),
        .m_last_of_run (m_last_of_run)
    );

endmodule

[hw/rtl/crd_queue.sv]
module crd_queue import crd_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    push,
    input  job_t    push_job,
    input  logic    pop,
    output job_t    head_job,
    output q_stat_t stat
);

    job_t               mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_AW:0]   cnt_reg, cnt_next;

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push && !pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

    assign head_job   = mem_reg[rd_ptr_reg];
    assign stat.full  = (cnt_reg == (FIFO_AW+1)'(FIFO_DEPTH));
    assign stat.empty = (cnt_reg == '0);

endmodule

[hw/rtl/crd_front.sv]
module crd_front import crd_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_report_byte,
    input  logic        s_last_byte,
    input  logic [5:0]  configured_mode,
    input  q_stat_t     q_stat,
    output logic        job_push,
    output job_t        job
);

    logic [7:0]       buf_reg [REPORT_BYTES];
    logic [7:0]       buf_next [REPORT_BYTES];
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [7:0]       att_reg, att_next;

    logic             acc;
    logic             rpt_end;
    logic [7:0]       view [BUF_SLOTS];
    logic [BUF_SLOTS-1:0] is_ff;
    logic [7:0]       rtype;

    logic             has_core, has_acc, has_ir, has_ext, ext_ff;
    logic [BUF_AW-1:0] ir_at, ext_at;
    logic [7:0]       ir_m;
    logic [9:0]       ir_x, ir_y;
    logic [7:0]       att_dec;
    logic [7:0]       att_val;
    logic [EV_COUNT-1:0] mask;

    // all bytes in [at, at+len) equal 0xff
    function automatic logic range_ff(input logic [BUF_SLOTS-1:0] v,
                                      input int at, input int len);
        logic r;
        r = 1'b1;
        for (int i = 0; i < BUF_SLOTS; i++) begin
            if (i >= at && i < at + len) begin
                r = r & v[i];
            end
        end
        return r;
    endfunction

    assign s_ready = !q_stat.full;
    assign acc     = s_valid && s_ready;
    assign rpt_end = acc && s_last_byte;

    // buffer contents with the byte of this cycle merged in
    always_comb begin
        for (int i = 0; i < BUF_SLOTS; i++) begin
            view[i] = '0;
        end
        for (int i = 0; i < REPORT_BYTES; i++) begin
            view[i] = (acc && pos_reg == POS_W'(i)) ? s_report_byte : buf_reg[i];
        end
        for (int i = 0; i < BUF_SLOTS; i++) begin
            is_ff[i] = (view[i] == 8'hFF);
        end
    end

    assign rtype = view[0];

    always_comb begin
        has_core = 1'b0;
        has_acc  = 1'b0;
        has_ir   = 1'b0;
        has_ext  = 1'b0;
        ext_ff   = 1'b0;
        ir_at    = '0;
        ext_at   = '0;
        att_dec  = att_reg;
        att_val  = '0;
        mask     = '0;
        unique case (rtype)
            RPT_CORE: begin
                if (configured_mode != RPT_CORE[5:0]) begin
                    mask[EV_REINIT] = 1'b1;
                end
            end
            RPT_CORE_ACC: begin
                has_core = 1'b1;
                has_acc  = 1'b1;
            end
            RPT_CORE_EXT8: begin
                has_core = 1'b1;
                has_ext  = 1'b1;
                ext_at   = BUF_AW'(3);
                ext_ff   = range_ff(is_ff, 3, 8);
            end
            RPT_CORE_ACC_IR: begin
                has_core = 1'b1;
                has_acc  = 1'b1;
                has_ir   = 1'b1;
                ir_at    = BUF_AW'(6);
            end
            RPT_CORE_EXT19: begin
                has_core = 1'b1;
                has_ext  = 1'b1;
                ext_at   = BUF_AW'(3);
                ext_ff   = range_ff(is_ff, 3, 19);
            end
            RPT_CORE_ACC_EXT16: begin
                has_core = 1'b1;
                has_acc  = 1'b1;
                has_ext  = 1'b1;
                ext_at   = BUF_AW'(6);
                ext_ff   = range_ff(is_ff, 6, 16);
            end
            RPT_CORE_IR_EXT9: begin
                has_core = 1'b1;
                has_ir   = 1'b1;
                ir_at    = BUF_AW'(3);
                has_ext  = 1'b1;
                ext_at   = BUF_AW'(13);
                ext_ff   = range_ff(is_ff, 13, 9);
            end
            RPT_CORE_ACC_IR_EXT6: begin
                has_core = 1'b1;
                has_acc  = 1'b1;
                has_ir   = 1'b1;
                ir_at    = BUF_AW'(6);
                has_ext  = 1'b1;
                ext_at   = BUF_AW'(16);
                ext_ff   = range_ff(is_ff, 16, 6);
            end
            RPT_EXT21: begin
                has_ext = 1'b1;
                ext_at  = BUF_AW'(1);
                ext_ff  = range_ff(is_ff, 1, 21);
            end
            RPT_STATUS: begin
                if (view[3][1]) begin
                    mask[EV_QUERY] = 1'b1;
                end else begin
                    att_dec          = ATT_NONE;
                    att_val          = ATT_NONE;
                    mask[EV_ATTACH]  = 1'b1;
                end
            end
            RPT_READ: begin
                if (view[3] == READ_ADDR_MARK && view[5] == READ_ID_MARK) begin
                    att_dec         = view[6];
                    att_val         = view[6];
                    mask[EV_ATTACH] = 1'b1;
                end
            end
            default: begin
            end
        endcase

        mask[EV_BUTTONS] = has_core;
        mask[EV_ACCEL]   = has_acc;
        if (has_ir && ir_x != IR_NONE && ir_y != IR_NONE) begin
            mask[EV_IR] = 1'b1;
        end
        if (has_ext && !ext_ff) begin
            if (att_reg == ATT_STICK_PAD) begin
                mask[EV_SP_BTN]   = 1'b1;
                mask[EV_SP_ACCEL] = 1'b1;
                mask[EV_SP_STICK] = 1'b1;
            end else if (att_reg == ATT_DUAL_PAD) begin
                mask[EV_DP_BTN]   = 1'b1;
                mask[EV_DP_LEFT]  = 1'b1;
                mask[EV_DP_RIGHT] = 1'b1;
                mask[EV_DP_TRIG]  = 1'b1;
            end
        end
    end

    // first ir point: low bytes plus packed high bits
    assign ir_m = view[BUF_AW'(ir_at + BUF_AW'(2))];
    assign ir_x = {ir_m[5:4], view[ir_at]};
    assign ir_y = {ir_m[7:6], view[BUF_AW'(ir_at + BUF_AW'(1))]};

    always_comb begin
        job.mask    = mask;
        job.buttons = {view[2], view[1]};
        job.acc_x   = view[3];
        job.acc_y   = view[4];
        job.acc_z   = view[5];
        job.ir_x    = IR_SPAN - {1'b0, ir_x};
        job.ir_y    = ir_y;
        for (int i = 0; i < 6; i++) begin
            job.ext[i] = (view[BUF_AW'(ext_at + BUF_AW'(i))] ^ EXT_KEY) + EXT_KEY;
        end
        job.att = att_val;
    end

    assign job_push = rpt_end && (|mask);

    always_comb begin
        pos_next = pos_reg;
        att_next = att_reg;
        for (int i = 0; i < REPORT_BYTES; i++) begin
            buf_next[i] = buf_reg[i];
        end
        if (rpt_end) begin
            pos_next = '0;
            att_next = att_dec;
            for (int i = 0; i < REPORT_BYTES; i++) begin
                buf_next[i] = '0;
            end
        end else if (acc && pos_reg < POS_W'(REPORT_BYTES)) begin
            pos_next = pos_reg + 1'b1;
            for (int i = 0; i < REPORT_BYTES; i++) begin
                if (pos_reg == POS_W'(i)) begin
                    buf_next[i] = s_report_byte;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= '0;
            att_reg <= ATT_NONE;
            for (int i = 0; i < REPORT_BYTES; i++) begin
                buf_reg[i] <= '0;
            end
        end else begin
            pos_reg <= pos_next;
            att_reg <= att_next;
            for (int i = 0; i < REPORT_BYTES; i++) begin
                buf_reg[i] <= buf_next[i];
            end
        end
    end

endmodule

[hw/rtl/crd_back.sv]
module crd_back import crd_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  q_stat_t     q_stat,
    input  job_t        head_job,
    output logic        pop,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [3:0]  m_event_kind,
    output logic [15:0] m_value_a,
    output logic [9:0]  m_value_b,
    output logic [7:0]  m_value_c,
    output logic        m_last_of_run
);

    job_t  job_reg, job_next;
    logic  m_valid_reg, m_valid_next;
    logic [3:0]  kind_reg, kind_next;
    logic [15:0] a_reg, a_next;
    logic [9:0]  b_reg, b_next;
    logic [7:0]  c_reg, c_next;
    logic        last_reg, last_next;

    logic                out_free, emit;
    logic [EV_COUNT-1:0] first, rest, mask_after;
    logic [3:0]          kind;
    logic [15:0]         va;
    logic [9:0]          vb;
    logic [7:0]          vc;
    logic [5:0][7:0]     e;

    assign out_free = !m_valid_reg || m_ready;
    assign emit     = out_free && (|job_reg.mask);
    assign first    = job_reg.mask & (~job_reg.mask + 1'b1);
    assign rest     = job_reg.mask & ~first;
    assign mask_after = emit ? rest : job_reg.mask;
    assign pop      = !q_stat.empty && (mask_after == '0);
    assign e        = job_reg.ext;

    always_comb begin
        kind = '0;
        for (int i = 0; i < EV_COUNT; i++) begin
            kind = kind | (first[i] ? 4'(i) : 4'd0);
        end
    end

    always_comb begin
        va = '0;
        vb = '0;
        vc = '0;
        unique case (kind)
            EV_BUTTONS: va = job_reg.buttons;
            EV_ACCEL: begin
                va = {8'd0, job_reg.acc_x};
                vb = {2'd0, job_reg.acc_y};
                vc = job_reg.acc_z;
            end
            EV_IR: begin
                va = {5'd0, job_reg.ir_x};
                vb = job_reg.ir_y;
            end
            EV_SP_BTN:   va = {14'd0, ~e[5][1:0]};
            EV_SP_ACCEL: begin
                va = {8'd0, e[2]};
                vb = {2'd0, e[3]};
                vc = e[4];
            end
            EV_SP_STICK: begin
                va = {8'd0, e[0]};
                vb = {2'd0, ~e[1]};
            end
            EV_DP_BTN:   va = ~{e[4], e[5]};
            EV_DP_LEFT: begin
                va = {10'd0, e[0][5:0]};
                vb = {4'd0, e[1][5:0]};
            end
            EV_DP_RIGHT: begin
                va = {11'd0, e[0][7:6], e[1][7:6], e[2][7]};
                vb = {5'd0, e[2][4:0]};
            end
            EV_DP_TRIG: begin
                va = {11'd0, e[2][6:5], e[3][7:5]};
                vb = {5'd0, e[3][4:0]};
            end
            EV_ATTACH:   va = {8'd0, job_reg.att};
            default: begin
            end
        endcase
    end

    always_comb begin
        job_next      = pop ? head_job : job_reg;
        job_next.mask = pop ? head_job.mask : mask_after;
        m_valid_next  = emit ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);
        kind_next     = emit ? kind : kind_reg;
        a_next        = emit ? va : a_reg;
        b_next        = emit ? vb : b_reg;
        c_next        = emit ? vc : c_reg;
        last_next     = emit ? (rest == '0) : last_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            job_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            job_reg     <= job_next;
            m_valid_reg <= m_valid_next;
        end
        kind_reg <= kind_next;
        a_reg    <= a_next;
        b_reg    <= b_next;
        c_reg    <= c_next;
        last_reg <= last_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_event_kind  = kind_reg;
    assign m_value_a     = a_reg;
    assign m_value_b     = b_reg;
    assign m_value_c     = c_reg;
    assign m_last_of_run = last_reg;

endmodule

[hw/rtl/crd_checker.sv]
module crd_assertions import crd_pkg::*; (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic [3:0]  m_event_kind,
    input logic [15:0] m_value_a,
    input logic [9:0]  m_value_b,
    input logic [7:0]  m_value_c,
    input logic        m_last_of_run
);

    // tracks whether a burst of events is in progress and its last kind
    logic       in_run_reg, in_run_next;
    logic [3:0] kind_reg, kind_next;

    always_comb begin
        in_run_next = in_run_reg;
        kind_next   = kind_reg;
        if (m_valid && m_ready) begin
            in_run_next = !m_last_of_run;
            kind_next   = m_event_kind;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_run_reg <= 1'b0;
            kind_reg   <= '0;
        end else begin
            in_run_reg <= in_run_next;
            kind_reg   <= kind_next;
        end
    end

    // stalled event holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_event_kind) && $stable(m_value_a)
            && $stable(m_value_b) && $stable(m_value_c) && $stable(m_last_of_run))
        else $error("event changed while stalled");

    // kinds rise within one burst
    a_kind_order: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && in_run_reg |-> m_event_kind > kind_reg)
        else $error("event kinds out of order within a report");

    // attach, query and reinit stand alone
    a_single: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_event_kind == EV_ATTACH || m_event_kind == EV_QUERY
            || m_event_kind == EV_REINIT) |-> m_last_of_run && !in_run_reg)
        else $error("control event not alone in its report");

    // third value only on accelerometer events
    a_value_c: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_event_kind != EV_ACCEL && m_event_kind != EV_SP_ACCEL
            |-> m_value_c == '0)
        else $error("value_c set on a non-accel event");

endmodule

bind controller_report_decoder crd_assertions u_crd_assertions (.*);

[tb/crd_checker.sv]
`timescale 1ns / 100ps

module crd_checker import crd_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [7:0]  s_report_byte,
    input  logic        s_last_byte,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [3:0]  m_event_kind,
    input  logic [15:0] m_value_a,
    input  logic [9:0]  m_value_b,
    input  logic [7:0]  m_value_c,
    input  logic        m_last_of_run,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [5:0]  cfg_data,
    output int          fail_count,
    output int          events_pending
);

    typedef struct packed {
        logic [3:0]  kind;
        logic [15:0] val_a;
        logic [9:0]  val_b;
        logic [7:0]  val_c;
        logic        last;
    } decoded_event_t;

    decoded_event_t   expected_events[$];
    logic [7:0]       rpt_bytes [0:BUF_SLOTS-1];
    logic [POS_W-1:0] rpt_pos;
    logic [7:0]       att_type;
    logic [5:0]       mode_reg;

    task automatic clear_report();
        for (int i = 0; i < BUF_SLOTS; i++) rpt_bytes[i] = 8'h00;
        rpt_pos = '0;
    endtask

    task automatic push_event(input logic [3:0] kind, input logic [15:0] a,
                              input logic [9:0] b, input logic [7:0] c);
        decoded_event_t ev;
        ev.kind  = kind;
        ev.val_a = a;
        ev.val_b = b;
        ev.val_c = c;
        ev.last  = 1'b0;
        expected_events.push_back(ev);
    endtask

    task automatic predict_buttons();
        push_event(EV_BUTTONS, {rpt_bytes[2], rpt_bytes[1]}, 10'd0, 8'h00);
    endtask

    task automatic predict_accel(input int at);
        push_event(EV_ACCEL, {8'h00, rpt_bytes[at]}, {2'b00, rpt_bytes[at+1]}, rpt_bytes[at+2]);
    endtask

    // first ir point, x mirrored, dropped when either coordinate is the empty marker
    task automatic predict_ir(input int at);
        logic [7:0]  hi;
        logic [9:0]  x;
        logic [9:0]  y;
        logic [10:0] mirrored;
        hi = rpt_bytes[at+2];
        x  = {hi[5:4], rpt_bytes[at]};
        y  = {hi[7:6], rpt_bytes[at+1]};
        if (x != IR_NONE && y != IR_NONE) begin
            mirrored = IR_SPAN - {1'b0, x};
            push_event(EV_IR, {5'b00000, mirrored}, y, 8'h00);
        end
    endtask

    task automatic predict_extension(input int at, input int len);
        logic [5:0][7:0] e;
        bit              all_ff;
        all_ff = 1'b1;
        for (int i = 0; i < len; i++)
            if (rpt_bytes[at+i] != 8'hFF) all_ff = 1'b0;
        if (!all_ff) begin
            for (int i = 0; i < 6; i++) e[i] = (rpt_bytes[at+i] ^ EXT_KEY) + EXT_KEY;
            if (att_type == ATT_STICK_PAD) begin
                push_event(EV_SP_BTN, {14'd0, ~e[5][1:0]}, 10'd0, 8'h00);
                push_event(EV_SP_ACCEL, {8'h00, e[2]}, {2'b00, e[3]}, e[4]);
                push_event(EV_SP_STICK, {8'h00, e[0]}, {2'b00, 8'd255 - e[1]}, 8'h00);
            end else if (att_type == ATT_DUAL_PAD) begin
                push_event(EV_DP_BTN, ~{e[4], e[5]}, 10'd0, 8'h00);
                push_event(EV_DP_LEFT, {10'd0, e[0][5:0]}, {4'd0, e[1][5:0]}, 8'h00);
                push_event(EV_DP_RIGHT, {11'd0, e[0][7:6], e[1][7:6], e[2][7]},
                           {5'd0, e[2][4:0]}, 8'h00);
                push_event(EV_DP_TRIG, {11'd0, e[2][6:5], e[3][7:5]},
                           {5'd0, e[3][4:0]}, 8'h00);
            end
        end
    endtask

    task automatic decode_report();
        case (rpt_bytes[0])
            RPT_CORE:
                if (mode_reg != RPT_CORE[5:0]) push_event(EV_REINIT, 16'd0, 10'd0, 8'h00);
            RPT_CORE_ACC: begin
                predict_buttons();
                predict_accel(3);
            end
            RPT_CORE_EXT8: begin
                predict_buttons();
                predict_extension(3, 8);
            end
            RPT_CORE_ACC_IR: begin
                predict_buttons();
                predict_accel(3);
                predict_ir(6);
            end
            RPT_CORE_EXT19: begin
                predict_buttons();
                predict_extension(3, 19);
            end
            RPT_CORE_ACC_EXT16: begin
                predict_buttons();
                predict_accel(3);
                predict_extension(6, 16);
            end
            RPT_CORE_IR_EXT9: begin
                predict_buttons();
                predict_ir(3);
                predict_extension(13, 9);
            end
            RPT_CORE_ACC_IR_EXT6: begin
                predict_buttons();
                predict_accel(3);
                predict_ir(6);
                predict_extension(16, 6);
            end
            RPT_EXT21:
                predict_extension(1, 21);
            RPT_STATUS:
                if (rpt_bytes[3][1]) begin
                    push_event(EV_QUERY, 16'd0, 10'd0, 8'h00);
                end else begin
                    att_type = ATT_NONE;
                    push_event(EV_ATTACH, 16'd0, 10'd0, 8'h00);
                end
            RPT_READ:
                if (rpt_bytes[3] == READ_ADDR_MARK && rpt_bytes[5] == READ_ID_MARK) begin
                    att_type = rpt_bytes[6];
                    push_event(EV_ATTACH, {8'h00, att_type}, 10'd0, 8'h00);
                end
            default: ;
        endcase
    endtask

    task automatic absorb_report_byte(input logic [7:0] b, input logic last);
        int             run_start;
        decoded_event_t tail;
        if (rpt_pos < REPORT_BYTES) begin
            rpt_bytes[rpt_pos] = b;
            rpt_pos = rpt_pos + 1'b1;
        end
        if (last) begin
            run_start = expected_events.size();
            decode_report();
            if (expected_events.size() > run_start) begin
                tail      = expected_events.pop_back();
                tail.last = 1'b1;
                expected_events.push_back(tail);
            end
            clear_report();
        end
    endtask

    task automatic check_event();
        decoded_event_t want;
        if (expected_events.size() == 0) begin
            fail_count++;
            if (fail_count <= 10)
                $display("unexpected event: kind %0d a %h b %h c %h last %b",
                         m_event_kind, m_value_a, m_value_b, m_value_c, m_last_of_run);
        end else begin
            want = expected_events.pop_front();
            if (want.kind != m_event_kind || want.val_a != m_value_a ||
                want.val_b != m_value_b || want.val_c != m_value_c ||
                want.last != m_last_of_run) begin
                fail_count++;
                if (fail_count <= 10)
                    $display("event mismatch: expected kind %0d a %h b %h c %h last %b, got kind %0d a %h b %h c %h last %b",
                             want.kind, want.val_a, want.val_b, want.val_c, want.last,
                             m_event_kind, m_value_a, m_value_b, m_value_c, m_last_of_run);
            end
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            clear_report();
            att_type = ATT_NONE;
            mode_reg = CFG_MODE_RESET;
            expected_events.delete();
        end else begin
            if (m_valid && m_ready) check_event();
            if (cfg_valid && cfg_ready) mode_reg = cfg_data;
            if (s_valid && s_ready) absorb_report_byte(s_report_byte, s_last_byte);
        end
        events_pending = expected_events.size();
    end

endmodule

[tb/tb.sv]
`timescale 1ns / 100ps

module tb;
    import crd_pkg::*;

    // sender and receiver idle rates per phase, in percent
    localparam int SLOW_SIDE_PCT  = 45;
    localparam int FAST_SIDE_PCT  = 18;
    // bytes of random reports per phase, three phases
    localparam int PHASE_BYTES    = 105;
    // long receiver hold-off so the job queue fills and s_ready drops
    localparam int RX_HOLD_CYCLES = 300;
    // core-only reports sent at the start of the hold-off, more than the queue holds
    localparam int FILL_REPORTS   = 8;
    // settle time after the last expected event, covers the decode pipeline
    localparam int DRAIN_CYCLES   = 12;

    logic        aclk          = 1'b0;
    logic        aresetn       = 1'b0;
    logic        s_valid       = 1'b0;
    logic        s_ready;
    logic [7:0]  s_report_byte = 8'h00;
    logic        s_last_byte   = 1'b0;
    logic        m_valid;
    logic        m_ready       = 1'b0;
    logic [3:0]  m_event_kind;
    logic [15:0] m_value_a;
    logic [9:0]  m_value_b;
    logic [7:0]  m_value_c;
    logic        m_last_of_run;
    logic        cfg_valid     = 1'b0;
    logic        cfg_ready;
    logic [5:0]  cfg_data      = 6'd0;

    int fail_count;
    int events_pending;

    int tx_idle_pct   = 0;
    int rx_idle_pct   = 0;
    // bumped by the stimulus, picked up by the receiver process
    int hold_requests = 0;

    // bytes of the report being sent, type byte first
    logic [7:0] report_q[$];

    always #4 aclk = ~aclk;

    controller_report_decoder u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_report_byte (s_report_byte),
        .s_last_byte   (s_last_byte),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_event_kind  (m_event_kind),
        .m_value_a     (m_value_a),
        .m_value_b     (m_value_b),
        .m_value_c     (m_value_c),
        .m_last_of_run (m_last_of_run),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    // watches all three channels, predicts the event stream and compares
    crd_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_report_byte  (s_report_byte),
        .s_last_byte    (s_last_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_event_kind   (m_event_kind),
        .m_value_a      (m_value_a),
        .m_value_b      (m_value_b),
        .m_value_c      (m_value_c),
        .m_last_of_run  (m_last_of_run),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .fail_count     (fail_count),
        .events_pending (events_pending)
    );

    // random byte biased toward the all-zero and all-one extremes
    function automatic logic [7:0] rand_byte();
        logic [31:0] r;
        r = $urandom;
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return r[7:0];
        endcase
    endfunction

    // one byte request; valid goes up at a falling edge and holds until accepted
    task automatic send_byte(input logic [7:0] b, input logic last);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid       <= 1'b1;
        s_report_byte <= b;
        s_last_byte   <= last;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    task automatic send_report();
        for (int i = 0; i < report_q.size(); i++)
            send_byte(report_q[i], i == report_q.size() - 1);
    endtask

    // drop valid once a stream of requests is over, called at a falling edge
    task automatic stop_sending();
        s_valid <= 1'b0;
        @(negedge aclk);
    endtask

    // wait until every predicted event is out, then let the pipeline settle
    task automatic wait_drained();
        while (events_pending != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    // mode register write, only issued while the block is idle
    task automatic write_mode(input logic [5:0] mode);
        cfg_valid <= 1'b1;
        cfg_data  <= mode;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // well-formed report with random content, plus some noise and odd lengths
    task automatic build_random_report();
        int         pick;
        int         len;
        int         ir_at;
        logic [7:0] kind_byte;
        pick = $urandom_range(0, 99);
        if (pick < 62) begin
            case ($urandom_range(0, 7))
                0:       kind_byte = RPT_CORE_ACC;
                1:       kind_byte = RPT_CORE_EXT8;
                2:       kind_byte = RPT_CORE_ACC_IR;
                3:       kind_byte = RPT_CORE_EXT19;
                4:       kind_byte = RPT_CORE_ACC_EXT16;
                5:       kind_byte = RPT_CORE_IR_EXT9;
                6:       kind_byte = RPT_CORE_ACC_IR_EXT6;
                default: kind_byte = RPT_EXT21;
            endcase
        end else if (pick < 70) begin
            kind_byte = RPT_CORE;
        end else if (pick < 74) begin
            kind_byte = RPT_STATUS;
        end else if (pick < 86) begin
            kind_byte = RPT_READ;
        end else begin
            // noise: any type byte at all, mostly unlisted ones
            kind_byte = rand_byte();
        end

        // mostly full length, some short (zero fill), some long (tail dropped)
        pick = $urandom_range(0, 99);
        if (pick < 60)
            len = REPORT_BYTES;
        else if (pick < 85)
            len = $urandom_range(1, REPORT_BYTES - 1);
        else
            len = $urandom_range(REPORT_BYTES + 1, REPORT_BYTES + 8);

        report_q.delete();
        report_q.push_back(kind_byte);
        for (int i = 1; i < len; i++) report_q.push_back(rand_byte());

        // query answers mostly carry valid markers and a known attachment
        if (kind_byte == RPT_READ && len >= 7 && $urandom_range(0, 9) < 8) begin
            report_q[3] = READ_ADDR_MARK;
            report_q[5] = READ_ID_MARK;
            case ($urandom_range(0, 4))
                0, 1:    report_q[6] = ATT_STICK_PAD;
                2, 3:    report_q[6] = ATT_DUAL_PAD;
                default: ;
            endcase
        end

        // all-ones body: extension data skipped, ir point empty
        if ($urandom_range(0, 9) == 0)
            for (int i = 1; i < len; i++) report_q[i] = 8'hFF;

        // empty ir marker on one coordinate only
        if ($urandom_range(0, 9) == 0) begin
            ir_at = (kind_byte == RPT_CORE_IR_EXT9) ? 3 : 6;
            if (ir_at + 2 < len) begin
                if ($urandom_range(0, 1)) begin
                    report_q[ir_at]   = 8'hFF;
                    report_q[ir_at+2] = report_q[ir_at+2] | 8'h30;
                end else begin
                    report_q[ir_at+1] = 8'hFF;
                    report_q[ir_at+2] = report_q[ir_at+2] | 8'hC0;
                end
            end
        end
    endtask

    task automatic run_random_phase(input int tx_pct, input int rx_pct);
        int sent;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        sent        = 0;
        while (sent < PHASE_BYTES) begin
            build_random_report();
            sent += report_q.size();
            send_report();
        end
        stop_sending();
        wait_drained();
    endtask

    // receiver: random ready, with a long hold-off whenever one is requested
    initial begin : rx_side
        int hold_left;
        int holds_taken;
        hold_left   = 0;
        holds_taken = 0;
        forever begin
            @(negedge aclk);
            if (holds_taken != hold_requests) begin
                holds_taken = hold_requests;
                hold_left   = RX_HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                m_ready <= 1'b0;
                hold_left--;
            end else begin
                m_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
            end
        end
    end

    initial begin : stimulus
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed reports, reset mode 0x37; sender idles lightly, receiver heavily
        tx_idle_pct = FAST_SIDE_PCT;
        rx_idle_pct = SLOW_SIDE_PCT;
        // core-only report under another mode: reinit
        report_q = '{RPT_CORE};
        send_report();
        // query answer naming the stick pad
        report_q = '{RPT_READ, 8'h00, 8'h00, READ_ADDR_MARK, 8'h00, READ_ID_MARK,
                     ATT_STICK_PAD};
        send_report();
        // short report, extension bytes read as zero
        report_q = '{RPT_CORE_EXT8, 8'h00, 8'hFF};
        send_report();
        // extension all ones: skipped, buttons all ones
        report_q = '{RPT_CORE_EXT8, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                     8'hFF, 8'hFF, 8'hFF, 8'hFF};
        send_report();
        // status with the query bit set
        report_q = '{RPT_STATUS, 8'h00, 8'h00, 8'h02};
        send_report();
        // status with the query bit clear: attachment removed
        report_q = '{RPT_STATUS};
        send_report();
        // ir x at the empty marker: no ir event
        report_q = '{RPT_CORE_ACC_IR, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF,
                     8'hFF, 8'h00, 8'h30};
        send_report();
        // ir x of zero mirrors to 1024
        report_q = '{RPT_CORE_ACC_IR, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05};
        send_report();
        // unlisted type
        report_q = '{8'h3F};
        send_report();
        // query answer with a bad id marker: ignored
        report_q = '{RPT_READ, 8'h00, 8'h00, READ_ADDR_MARK};
        send_report();
        // dual pad attachment, then its extension fields
        report_q = '{RPT_READ, 8'h00, 8'h00, READ_ADDR_MARK, 8'h00, READ_ID_MARK,
                     ATT_DUAL_PAD};
        send_report();
        report_q = '{RPT_EXT21, 8'h55};
        send_report();
        stop_sending();
        wait_drained();

        // matching mode: core-only report is silent
        write_mode(RPT_CORE[5:0]);
        report_q = '{RPT_CORE};
        send_report();
        stop_sending();
        wait_drained();
        // top of the mode range: reinit again
        write_mode(6'h3F);
        report_q = '{RPT_CORE};
        send_report();
        stop_sending();
        wait_drained();

        // sender idles lightly, receiver heavily
        write_mode($urandom_range(48, 63));
        run_random_phase(FAST_SIDE_PCT, SLOW_SIDE_PCT);
        // the other way round, matching mode
        write_mode(RPT_CORE[5:0]);
        run_random_phase(SLOW_SIDE_PCT, FAST_SIDE_PCT);
        // no idling, long receiver hold-off at the start fills the job queue
        write_mode(CFG_MODE_RESET);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        hold_requests++;
        // reinit reports pile up behind the held output until s_ready drops
        for (int i = 0; i < FILL_REPORTS; i++) begin
            report_q = '{RPT_CORE};
            send_report();
        end
        run_random_phase(0, 0);

        if (fail_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial begin : watchdog
        #5_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

[sim.f]
hw/rtl/crd_pkg.sv
hw/rtl/crd_queue.sv
hw/rtl/crd_front.sv
hw/rtl/crd_back.sv
hw/rtl/controller_report_decoder.sv
hw/rtl/crd_checker.sv
tb/crd_checker.sv
tb/tb.sv
